[sv/mcfe_pkg.sv]
package mcfe_pkg;

	localparam int FRAME_BYTES = 18;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int CRC_BYTES   = 13;
	localparam int CRC_CNT_W   = $clog2(CRC_BYTES);

	localparam logic [7:0]  FRAME_SOF  = 8'h02;
	localparam logic [7:0]  FRAME_EOF  = 8'h03;
	localparam logic [7:0]  FRAME_LEN  = 8'd13;
	localparam logic [7:0]  CODE_RESET = 8'h5B;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	typedef struct packed {
		logic signed [31:0] position_mdeg;
		logic        [31:0] velocity;
		logic        [31:0] acceleration;
	} in_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} out_t;

	// One frame, ready to serialize: code byte, the three words and the checksum.
	typedef struct packed {
		logic [7:0]  code;
		logic [31:0] pos;
		logic [31:0] vel;
		logic [31:0] acc;
		logic [15:0] crc;
	} frame_rec_t;

	typedef struct packed {
		logic not_empty;
		logic not_full;
	} q_status_t;

	// One byte of CRC-16/XMODEM, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[sv/motor_command_frame_encoder_unit.sv]
// Throughput: one frame byte per cycle while pop stays high and the queue holds a frame;
// the byte serializer in the back end sets that figure.
// The front end runs the checksum over its 13 covered bytes, one byte per cycle, then hands the frame on.
// Reset (arst_n low, asynchronous) empties the queue and output stage and sets the code to 0x5B.
module motor_command_frame_encoder_unit import mcfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_t        item,
	output logic       empty,
	input  logic       pop,
	output out_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	// The command code register is written whenever a configuration beat arrives.
	// It is sampled into the frame record at the moment a command beat is accepted,
	// so a frame in flight always carries the code that was current when it came in.
	logic [7:0] code_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= CODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			code_q <= cfg_data;
		end
	end

	// The front end latches the command, runs the CRC over the code byte and the
	// twelve data bytes, and offers the finished frame record to the queue.
	frame_rec_t front_rec;
	logic       front_rec_valid;
	frame_rec_t q_rec;
	q_status_t  q_st;
	logic       q_pop;

	mcfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.code      (code_q),
		.q_st      (q_st),
		.rec_valid (front_rec_valid),
		.rec       (front_rec)
	);

	// A two-entry queue lets the front end finish the next checksum while the
	// back end is still sending the current frame.
	mcfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_rec_valid),
		.wr_data (front_rec),
		.rd_en   (q_pop),
		.rd_data (q_rec),
		.st      (q_st)
	);

	// The back end walks the 18 frame positions and drives an output register;
	// it loads the next record on the same edge that issues a closing byte, so
	// frames follow one another without a gap.
	mcfe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_st   (q_st),
		.q_rec  (q_rec),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	// The front end only turns busy because a command beat was accepted.
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("front end became busy without an accepted command");

	// The marked byte is always the closing delimiter.
	a_last_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.frame_last) |-> (result.frame_byte == FRAME_EOF))
		else $error("frame_last set on a byte other than the closing delimiter");

	// The back end never takes a record from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_st.not_empty)
		else $error("back end read from an empty queue");

	// A byte following a closing byte that was taken must open a new frame.
	a_sof_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && result.frame_last) ##1 !empty |-> (result.frame_byte == FRAME_SOF))
		else $error("new frame does not start with the opening delimiter");
`endif

endmodule

[sv/mcfe_front.sv]
module mcfe_front import mcfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_t        item,
	input  logic [7:0] code,
	input  q_status_t  q_st,
	output logic       rec_valid,
	output frame_rec_t rec
);

	logic                 busy_q;
	logic                 crc_done_q;
	logic [CRC_CNT_W-1:0] cnt_q;
	logic [103:0]         sh_q;
	frame_rec_t           rec_q;
	logic                 accept;
	logic                 hand_off;

	assign full      = busy_q;
	assign accept    = push && !busy_q;
	assign hand_off  = crc_done_q && q_st.not_full;
	assign rec_valid = crc_done_q;
	assign rec       = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			crc_done_q <= 1'b0;
			cnt_q      <= '0;
		end else if (accept) begin
			busy_q     <= 1'b1;
			crc_done_q <= 1'b0;
			cnt_q      <= '0;
		end else if (hand_off) begin
			busy_q     <= 1'b0;
			crc_done_q <= 1'b0;
		end else if (busy_q && !crc_done_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CRC_CNT_W'(CRC_BYTES - 1)) begin
				crc_done_q <= 1'b1;
			end
		end
	end

	// The shift line feeds one covered byte per cycle into the checksum.
	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q      <= {code, item.position_mdeg, item.velocity, item.acceleration};
			rec_q.code <= code;
			rec_q.pos  <= item.position_mdeg;
			rec_q.vel  <= item.velocity;
			rec_q.acc  <= item.acceleration;
			rec_q.crc  <= '0;
		end else if (busy_q && !crc_done_q) begin
			sh_q      <= {sh_q[95:0], 8'h00};
			rec_q.crc <= crc_byte(rec_q.crc, sh_q[103:96]);
		end
	end

endmodule

[sv/mcfe_queue.sv]
module mcfe_queue import mcfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  frame_rec_t wr_data,
	input  logic       rd_en,
	output frame_rec_t rd_data,
	output q_status_t  st
);

	frame_rec_t  mem [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_wr;
	logic        do_rd;

	assign st.not_empty = (count_q != 2'd0);
	assign st.not_full  = (count_q != 2'd2);
	assign do_wr        = wr_en && st.not_full;
	assign do_rd        = rd_en && st.not_empty;
	assign rd_data      = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[sv/mcfe_back.sv]
module mcfe_back import mcfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_status_t  q_st,
	input  frame_rec_t q_rec,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output out_t       result
);

	frame_rec_t       cur_q;
	logic             active_q;
	logic [IDX_W-1:0] idx_q;
	out_t             out_q;
	logic             out_valid_q;
	logic             advance;
	logic             at_last;
	logic [7:0]       byte_sel;

	assign advance = !out_valid_q || pop;
	assign at_last = (idx_q == IDX_W'(FRAME_BYTES - 1));
	assign q_pop   = q_st.not_empty && (!active_q || (advance && at_last));
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_comb begin
		case (idx_q)
			5'd0:    byte_sel = FRAME_SOF;
			5'd1:    byte_sel = FRAME_LEN;
			5'd2:    byte_sel = cur_q.code;
			5'd3:    byte_sel = cur_q.pos[31:24];
			5'd4:    byte_sel = cur_q.pos[23:16];
			5'd5:    byte_sel = cur_q.pos[15:8];
			5'd6:    byte_sel = cur_q.pos[7:0];
			5'd7:    byte_sel = cur_q.vel[31:24];
			5'd8:    byte_sel = cur_q.vel[23:16];
			5'd9:    byte_sel = cur_q.vel[15:8];
			5'd10:   byte_sel = cur_q.vel[7:0];
			5'd11:   byte_sel = cur_q.acc[31:24];
			5'd12:   byte_sel = cur_q.acc[23:16];
			5'd13:   byte_sel = cur_q.acc[15:8];
			5'd14:   byte_sel = cur_q.acc[7:0];
			5'd15:   byte_sel = cur_q.crc[15:8];
			5'd16:   byte_sel = cur_q.crc[7:0];
			5'd17:   byte_sel = FRAME_EOF;
			default: byte_sel = FRAME_EOF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= active_q;
			end
			if (q_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (advance && active_q) begin
				if (at_last) begin
					active_q <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rec;
		end
		if (advance && active_q) begin
			out_q.frame_byte <= byte_sel;
			out_q.frame_last <= at_last;
		end
	end

endmodule
